FILE: hdl/sllex_pkg.sv
// ----------------------------------------------------------------------------
// sllex_pkg
// Shared types, codes and helpers for the stack language line lexer.
// ----------------------------------------------------------------------------
package sllex_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_QUOTE   = 8'd34;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_MINUS   = 8'd45;

    localparam logic [7:0] CFG_FIRST_RST  = 8'd47;
    localparam logic [7:0] CFG_SECOND_RST = 8'd47;

    localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

    localparam logic [1:0] REC_TEXT = 2'd0;
    localparam logic [1:0] REC_END  = 2'd1;
    localparam logic [1:0] REC_EOC  = 2'd2;

    localparam logic [1:0] KIND_WORD    = 2'd0;
    localparam logic [1:0] KIND_INT     = 2'd1;
    localparam logic [1:0] KIND_STRING  = 2'd2;
    localparam logic [1:0] KIND_UNTERM  = 2'd3;

    localparam logic REG_FIRST  = 1'b0;
    localparam logic REG_SECOND = 1'b1;

    typedef enum logic [2:0] {
        M_IDLE,
        M_HELD,
        M_WORD,
        M_STRING,
        M_COMMENT
    } mode_t;

    typedef struct packed {
        logic neg;
        logic sgn;
        logic digit;
        logic numeric;
        logic ovf;
    } nf_t;

    typedef struct packed {
        nf_t         nf;
        logic [63:0] mag;
    } num_t;

    // records produced by one input byte: text bytes, then end, then eoc
    typedef struct packed {
        logic [1:0]  ntext;
        logic [7:0]  t0;
        logic [7:0]  t1;
        logic        has_end;
        logic [1:0]  kind;
        logic [31:0] row;
        logic [15:0] col;
        logic [63:0] val;
        logic [15:0] len;
        logic        has_eoc;
    } bundle_t;

    // one byte of a word through the number recognizer
    function automatic num_t word_byte(num_t s, logic [7:0] c);
        num_t        r;
        logic [67:0] prod;
        logic [63:0] lim;
        r    = s;
        lim  = s.nf.neg ? LIM_NEG : LIM_POS;
        prod = {1'b0, s.mag, 3'b000} + {3'b000, s.mag, 1'b0}
             + {64'd0, 4'(c - CH_ZERO)};
        if (s.nf.numeric) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                r.nf.digit = 1'b1;
                if (!s.nf.ovf) begin
                    if (prod > {4'd0, lim}) begin
                        r.nf.ovf = 1'b1;
                    end else begin
                        r.mag = prod[63:0];
                    end
                end
            end else if (!s.nf.digit && !s.nf.sgn && (c == CH_PLUS || c == CH_MINUS)) begin
                r.nf.sgn = 1'b1;
                r.nf.neg = (c == CH_MINUS);
            end else if (!s.nf.digit && !s.nf.sgn
                         && (c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13)) begin
                r = s;
            end else begin
                r.nf.numeric = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/sllex_front.sv
// ----------------------------------------------------------------------------
// sllex_front
// Classifies one source byte per cycle when accepted and builds its records.
// ----------------------------------------------------------------------------
module sllex_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        ch,
    input  logic              is_end,
    input  logic [7:0]        cfg_first,
    input  logic [7:0]        cfg_second,
    output logic              push,
    output sllex_pkg::bundle_t bundle
);
    import sllex_pkg::*;

    mode_t       mode_reg,  mode_next;
    logic [7:0]  held_reg,  held_next;
    logic [31:0] row_reg,   row_next;
    logic        ls_reg,    ls_next;
    logic [15:0] col_reg,   col_next;
    logic [15:0] tcol_reg,  tcol_next;
    logic [15:0] tlen_reg,  tlen_next;
    num_t        num_reg,   num_next;

    always_comb begin
        logic       do_begin;
        logic       do_tok;
        logic       do_fin;
        logic [7:0] b;
        logic [15:0] p;
        num_t       zero_num;

        mode_next = mode_reg;
        held_next = held_reg;
        row_next  = row_reg;
        ls_next   = ls_reg;
        col_next  = col_reg;
        tcol_next = tcol_reg;
        tlen_next = tlen_reg;
        num_next  = num_reg;
        bundle    = '0;
        do_begin  = 1'b0;
        do_tok    = 1'b0;
        do_fin    = 1'b0;
        b         = ch;
        p         = col_reg;
        zero_num  = '0;
        zero_num.nf.numeric = 1'b1;

        if (is_end || ch == CH_NEWLINE) begin
            if (mode_reg == M_HELD) begin
                do_begin = 1'b1;
                b        = held_reg;
                p        = tcol_reg;
            end
            do_fin = 1'b1;
        end else begin
            if (!ls_reg) begin
                ls_next = 1'b1;
                if (row_reg != '1) row_next = row_reg + 32'd1;
            end
            if (col_reg != '1) col_next = col_reg + 16'd1;
            case (mode_reg)
                M_IDLE: begin
                    if (ch == CH_SPACE) begin
                        mode_next = M_IDLE;
                    end else if (ch == cfg_first) begin
                        held_next = ch;
                        tcol_next = col_reg;
                        mode_next = M_HELD;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                M_HELD: begin
                    if (ch == cfg_second) begin
                        mode_next = M_COMMENT;
                    end else begin
                        do_begin = 1'b1;
                        b        = held_reg;
                        p        = tcol_reg;
                        do_tok   = 1'b1;
                    end
                end
                M_WORD, M_STRING: do_tok = 1'b1;
                default: mode_next = mode_reg;
            endcase
        end

        if (do_begin) begin
            tcol_next = p;
            tlen_next = '0;
            num_next  = zero_num;
            if (b == CH_QUOTE) begin
                mode_next = M_STRING;
            end else begin
                mode_next    = M_WORD;
                bundle.t0    = b;
                bundle.ntext = 2'd1;
                tlen_next    = 16'd1;
                num_next     = word_byte(zero_num, b);
            end
        end

        if (do_tok) begin
            if (mode_next == M_WORD && ch == CH_SPACE) begin
                do_fin = 1'b1;
            end else if (mode_next == M_STRING && ch == CH_QUOTE) begin
                bundle.has_end = 1'b1;
                bundle.kind    = KIND_STRING;
                mode_next      = M_IDLE;
            end else begin
                if (bundle.ntext == 2'd0) bundle.t0 = ch;
                else                      bundle.t1 = ch;
                bundle.ntext = bundle.ntext + 2'd1;
                if (tlen_next != '1) tlen_next = tlen_next + 16'd1;
                if (mode_next == M_WORD) num_next = word_byte(num_next, ch);
            end
        end

        if (do_fin) begin
            if (mode_next == M_WORD) begin
                bundle.has_end = 1'b1;
                if (num_next.nf.numeric && num_next.nf.digit && !num_next.nf.ovf) begin
                    bundle.kind = KIND_INT;
                    bundle.val  = num_next.nf.neg ? (64'd0 - num_next.mag) : num_next.mag;
                end else begin
                    bundle.kind = KIND_WORD;
                end
            end else if (mode_next == M_STRING) begin
                bundle.has_end = 1'b1;
                bundle.kind    = KIND_UNTERM;
            end
            mode_next = M_IDLE;
        end

        if (bundle.has_end) begin
            bundle.row = row_next;
            bundle.col = tcol_next;
            bundle.len = tlen_next;
        end

        if (is_end) begin
            bundle.has_eoc = 1'b1;
            mode_next = M_IDLE;
            held_next = '0;
            row_next  = '0;
            ls_next   = 1'b0;
            col_next  = '0;
            tcol_next = '0;
            tlen_next = '0;
            num_next  = '0;
        end else if (ch == CH_NEWLINE) begin
            ls_next   = 1'b0;
            col_next  = '0;
        end
    end

    assign push = accept && (bundle.ntext != 2'd0 || bundle.has_end || bundle.has_eoc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            held_reg <= '0;
            row_reg  <= '0;
            ls_reg   <= 1'b0;
            col_reg  <= '0;
            tcol_reg <= '0;
            tlen_reg <= '0;
            num_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            row_reg  <= row_next;
            ls_reg   <= ls_next;
            col_reg  <= col_next;
            tcol_reg <= tcol_next;
            tlen_reg <= tlen_next;
            num_reg  <= num_next;
        end
    end

endmodule

FILE: hdl/sllex_fifo.sv
// ----------------------------------------------------------------------------
// sllex_fifo
// Short queue of record bundles between the front and back parts.
// ----------------------------------------------------------------------------
module sllex_fifo #(
    parameter int DEPTH = sllex_pkg::FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sllex_pkg::bundle_t wr_data,
    input  logic               pop,
    output sllex_pkg::bundle_t rd_data,
    output logic               full,
    output logic               empty
);
    import sllex_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg,    cnt_next;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)      cnt_next = cnt_reg + CW'(1);
        else if (!push && pop) cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: hdl/sllex_back.sv
// ----------------------------------------------------------------------------
// sllex_back
// Unpacks queued bundles into one output beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module sllex_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  sllex_pkg::bundle_t head,
    input  logic               empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [143:0]       m_tdata,
    output logic [1:0]         m_tuser
);
    import sllex_pkg::*;

    logic [1:0]   sel_reg,  sel_next;
    logic         vld_reg,  vld_next;
    logic [143:0] data_reg, data_next;
    logic [1:0]   user_reg, user_next;

    logic [3:0] present;
    logic [3:0] avail;
    logic [3:0] after;
    logic [1:0] cur;
    logic       last;
    logic       load;

    // slot order: first text, second text, end record, end of content
    assign present = {head.has_eoc, head.has_end, head.ntext == 2'd2, head.ntext != 2'd0};
    assign avail   = present & (4'b1111 << sel_reg);

    always_comb begin
        cur = 2'd3;
        for (int i = 3; i >= 0; i--) begin
            if (avail[i]) cur = 2'(i);
        end
    end

    assign after = present & ~((4'b0010 << cur) - 4'd1);
    assign last  = (after == 4'd0);
    assign load  = !empty && (!vld_reg || m_tready);
    assign pop   = load && last;

    always_comb begin
        sel_next  = sel_reg;
        vld_next  = vld_reg;
        data_next = data_reg;
        user_next = user_reg;
        if (load) begin
            vld_next  = 1'b1;
            sel_next  = last ? 2'd0 : cur + 2'd1;
            data_next = '0;
            case (cur)
                2'd0: begin
                    user_next        = REC_TEXT;
                    data_next[7:0]   = head.t0;
                end
                2'd1: begin
                    user_next        = REC_TEXT;
                    data_next[7:0]   = head.t1;
                end
                2'd2: begin
                    user_next          = REC_END;
                    data_next[9:8]     = head.kind;
                    data_next[41:10]   = head.row;
                    data_next[57:42]   = head.col;
                    data_next[121:58]  = head.val;
                    data_next[137:122] = head.len;
                end
                default: user_next = REC_EOC;
            endcase
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

FILE: hdl/stack_language_line_lexer_top.sv
// ----------------------------------------------------------------------------
// stack_language_line_lexer_top
// Lexer for a small stack language, one source byte per beat.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries one source byte, s_tuser marks end of content.
// Output stream: one beat per record; m_tuser says text byte, token end or
// end of content, m_tdata carries the record fields.
// Throughput: one source byte per cycle while the output keeps up. A byte can
// cause up to three output beats, and the output port moves one beat per
// cycle, so that port sets the sustained rate when tokens are short.
// An accepted byte's records are written into the bundle queue, then loaded
// into the output register. A bundle queue of FIFO_DEPTH entries separates
// the classifier from the output; when m_tready is low the queue fills and
// s_tready drops. Reset clears all lexer state and loads both comment marker
// bytes with '/'. The user must write the comment marker bytes over the APB
// port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stack_language_line_lexer_top #(
    parameter int FIFO_DEPTH = sllex_pkg::FIFO_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tuser,   // [0] is_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] text_byte, [9:8] kind, [41:10] row, [57:42] col,
    // [121:58] int_value, [137:122] length, [143:138] zero
    output logic [143:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] rec
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sllex_pkg::*;

    logic [7:0] cf_reg;
    logic [7:0] cs_reg;
    logic       accept;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    bundle_t    fbundle;
    bundle_t    head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SECOND) ? {24'd0, cs_reg} : {24'd0, cf_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cf_reg <= CFG_FIRST_RST;
            cs_reg <= CFG_SECOND_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_FIRST) cf_reg <= pwdata[7:0];
            else                       cs_reg <= pwdata[7:0];
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    sllex_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .ch         (s_tdata),
        .is_end     (s_tuser),
        .cfg_first  (cf_reg),
        .cfg_second (cs_reg),
        .push       (push),
        .bundle     (fbundle)
    );

    sllex_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (fbundle),
        .pop     (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    sllex_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: hdl/sllex_checker.sv
// ----------------------------------------------------------------------------
// sllex_checker
// Port-level checks on the lexer's output stream and register port.
// ----------------------------------------------------------------------------
module sllex_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         pready
);
    import sllex_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output beat right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled beat changed");

    a_rec_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == REC_TEXT || m_tuser == REC_END || m_tuser == REC_EOC))
        else $error("bad record code");

    a_text_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != REC_END |-> m_tdata[143:8] == '0)
        else $error("non-end beat carries token fields");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("register port not ready");

endmodule

bind stack_language_line_lexer_top sllex_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

FILE: test/stack_language_line_lexer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_language_line_lexer_top_tb
// Drives source bytes into the lexer under random stalls on both streams,
// keeps a byte-level model of the token state and checks every output beat.
// ----------------------------------------------------------------------------
module stack_language_line_lexer_top_tb;
    import sllex_pkg::*;

    typedef struct packed {
        logic [1:0]  rec;
        logic [7:0]  text;
        logic [1:0]  kind;
        logic [31:0] row;
        logic [15:0] col;
        logic [63:0] val;
        logic [15:0] len;
    } lex_rec_t;

    typedef struct {
        logic [7:0] ch;
        logic       is_end;
        logic       typed;
        lex_rec_t   want;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 200000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    stack_language_line_lexer_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // lexer model state
    logic [7:0]  cf_byte, cs_byte;
    mode_t       lx_mode;
    logic [7:0]  held;
    logic [31:0] row_cnt;
    logic        line_on;
    logic [15:0] column, tok_col, tok_len;
    logic [63:0] mag;
    logic        f_neg, f_sgn, f_dig, f_num, f_ovf;

    lex_rec_t    tokens_due[$];
    logic [7:0]  src_q[$];
    int          errors = 0;
    int          beats_seen = 0;
    int          bytes_sent = 0;
    int          snd_idle = 0, rcv_idle = 0;
    int          hold_cycles = 0;
    longint      cycles = 0;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch beat %0d %s: got %0h want %0h", beats_seen, what, got, want);
        errors++;
    endtask

    task automatic clear_lexer();
        lx_mode = M_IDLE; held = '0; row_cnt = '0; line_on = 1'b0;
        column = '0; tok_col = '0; tok_len = '0; mag = '0;
        {f_neg, f_sgn, f_dig, f_num, f_ovf} = '0;
    endtask

    task automatic emit_text(logic [7:0] c);
        if (tok_len != 16'hFFFF) tok_len++;
        tokens_due.push_back('{REC_TEXT, c, 2'd0, 32'd0, 16'd0, 64'd0, 16'd0});
    endtask

    task automatic emit_end(logic [1:0] k, logic [63:0] v);
        tokens_due.push_back('{REC_END, 8'd0, k, row_cnt, tok_col, v, tok_len});
        lx_mode = M_IDLE;
    endtask

    task automatic word_byte(logic [7:0] c);
        logic [63:0] d, lim;
        emit_text(c);
        if (!f_num) return;
        if (c >= "0" && c <= "9") begin
            d = 64'(c - "0");
            lim = f_neg ? LIM_NEG : LIM_POS;
            f_dig = 1'b1;
            if (!f_ovf) begin
                if (mag > (lim - d) / 10) f_ovf = 1'b1;
                else mag = mag * 10 + d;
            end
        end else if (!f_dig && !f_sgn && (c == "+" || c == "-")) begin
            f_sgn = 1'b1;
            f_neg = (c == "-");
        end else if (!f_dig && !f_sgn && (c == 9 || c == 11 || c == 12 || c == 13)) begin
            // leading white space allowed by the number syntax
        end else begin
            f_num = 1'b0;
        end
    endtask

    task automatic start_tok(logic [7:0] c, logic [15:0] pos);
        tok_col = pos; tok_len = '0; mag = '0;
        {f_neg, f_sgn, f_dig, f_ovf} = '0;
        f_num = 1'b1;
        if (c == CH_QUOTE) begin
            lx_mode = M_STRING;
        end else begin
            lx_mode = M_WORD;
            word_byte(c);
        end
    endtask

    task automatic finish_tok();
        if (lx_mode == M_HELD) start_tok(held, tok_col);
        if (lx_mode == M_WORD) begin
            if (f_num && f_dig && !f_ovf) emit_end(KIND_INT, f_neg ? -mag : mag);
            else emit_end(KIND_WORD, 64'd0);
        end else if (lx_mode == M_STRING) begin
            emit_end(KIND_UNTERM, 64'd0);
        end
        lx_mode = M_IDLE;
    endtask

    task automatic in_token(logic [7:0] c);
        if (lx_mode == M_WORD) begin
            if (c == CH_SPACE) finish_tok();
            else word_byte(c);
        end else if (c == CH_QUOTE) begin
            emit_end(KIND_STRING, 64'd0);
        end else begin
            emit_text(c);
        end
    endtask

    task automatic lex_byte(logic [7:0] c, logic is_end);
        logic [15:0] pos;
        if (is_end) begin
            finish_tok();
            tokens_due.push_back('{REC_EOC, 8'd0, 2'd0, 32'd0, 16'd0, 64'd0, 16'd0});
            clear_lexer();
            return;
        end
        if (c == CH_NEWLINE) begin
            finish_tok();
            line_on = 1'b0; column = '0; lx_mode = M_IDLE;
            return;
        end
        if (!line_on) begin
            line_on = 1'b1;
            if (row_cnt != 32'hFFFF_FFFF) row_cnt++;
        end
        pos = column;
        if (column != 16'hFFFF) column++;
        case (lx_mode)
            M_IDLE: begin
                if (c == CH_SPACE) begin
                end else if (c == cf_byte) begin
                    held = c; tok_col = pos; lx_mode = M_HELD;
                end else begin
                    start_tok(c, pos);
                end
            end
            M_HELD: begin
                if (c == cs_byte) begin
                    lx_mode = M_COMMENT;
                end else begin
                    start_tok(held, tok_col);
                    in_token(c);
                end
            end
            M_WORD, M_STRING: in_token(c);
            default: ;
        endcase
    endtask

    // one input beat; a typed row replaces the model's results with its own record
    task automatic send(logic [7:0] c, logic e, logic typed = 1'b0, lex_rec_t want = '0);
        int sz;
        if (snd_idle > 0) begin
            while ($urandom_range(99) < snd_idle) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tdata <= c;
        s_tuser <= e;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sz = tokens_due.size();
        lex_byte(c, e);
        if (typed) begin
            while (tokens_due.size() > sz) void'(tokens_due.pop_back());
            tokens_due.push_back(want);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic flush_src();
        while (src_q.size() > 0) send(src_q.pop_front(), 1'b0);
    endtask

    task automatic push_str(string s);
        foreach (s[i]) src_q.push_back(s[i]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (tokens_due.size() == 0);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(logic reg_sel, logic [7:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {reg_sel, 2'b00}; pwdata <= {24'd0, v};
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (reg_sel == REG_FIRST) cf_byte = v;
        else cs_byte = v;
    endtask

    // random token bytes that never split the token
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_SPACE || b == CH_NEWLINE || b == CH_QUOTE);
        return b;
    endfunction

    task automatic gen_line();
        int ntok, n;
        logic [63:0] v;
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) src_q.push_back(8'($urandom));
        end else begin
            ntok = $urandom_range(0, 4);
            repeat ($urandom_range(0, 1)) src_q.push_back(CH_SPACE);
            for (int t = 0; t < ntok; t++) begin
                case ($urandom_range(6))
                    0, 1: begin
                        v = {$urandom, $urandom};
                        if ($urandom_range(3) == 0) v = 64'($signed(32'($urandom)) >>> 20);
                        if ($urandom_range(5) == 0) src_q.push_back(8'($urandom_range(11, 13)));
                        if ($urandom_range(4) == 0 && !v[63]) src_q.push_back(CH_PLUS);
                        push_str($sformatf("%0d", $signed(v)));
                    end
                    2: push_str($sformatf("%0d%0d", $urandom, $urandom_range(0, 999999)));
                    3: begin
                        n = $urandom_range(1, 6);
                        repeat (n) src_q.push_back(plain_byte());
                    end
                    4: begin
                        src_q.push_back(CH_QUOTE);
                        n = $urandom_range(0, 5);
                        repeat (n) begin
                            src_q.push_back(plain_byte());
                            if ($urandom_range(7) == 0) src_q.push_back(CH_SPACE);
                        end
                        if ($urandom_range(5) != 0) src_q.push_back(CH_QUOTE);
                        if ($urandom_range(2) == 0) continue;
                    end
                    5: begin
                        src_q.push_back(cf_byte);
                        src_q.push_back($urandom_range(3) == 0 ? plain_byte() : cs_byte);
                        n = $urandom_range(0, 4);
                        repeat (n) src_q.push_back(8'($urandom));
                    end
                    default: begin
                        src_q.push_back(cf_byte);
                        src_q.push_back(CH_NEWLINE);
                    end
                endcase
                src_q.push_back(CH_SPACE);
            end
        end
        src_q.push_back(CH_NEWLINE);
        if ($urandom_range(4) == 0) src_q.push_back(CH_NEWLINE);
        flush_src();
        if ($urandom_range(11) == 0) send(8'($urandom), 1'b1);
    endtask

    // output side: random stall, long hold-off when asked
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (rcv_idle == 0) || ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        lex_rec_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[41:10], m_tdata[57:42],
                    m_tdata[121:58], m_tdata[137:122]};
            beats_seen++;
            if (tokens_due.size() == 0) begin
                report("unexpected beat", 64'(got.rec), 64'hx);
            end else begin
                want = tokens_due.pop_front();
                if (got.rec  !== want.rec)  report("rec",  64'(got.rec),  64'(want.rec));
                if (got.text !== want.text) report("text", 64'(got.text), 64'(want.text));
                if (got.kind !== want.kind) report("kind", 64'(got.kind), 64'(want.kind));
                if (got.row  !== want.row)  report("row",  64'(got.row),  64'(want.row));
                if (got.col  !== want.col)  report("col",  64'(got.col),  64'(want.col));
                if (got.val  !== want.val)  report("value", got.val, want.val);
                if (got.len  !== want.len)  report("length", 64'(got.len), 64'(want.len));
            end
        end
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout with %0d beats outstanding", tokens_due.size());
            $display("stack_language_line_lexer_top_tb: FAIL");
            $finish;
        end
    end

    stim_row_t dir_rows[] = '{
        '{8'd0,   1'b1, 1'b1, '{REC_EOC,  8'd0,   2'd0, 32'd0, 16'd0, 64'd0, 16'd0}},
        '{"A",    1'b0, 1'b1, '{REC_TEXT, "A",    2'd0, 32'd0, 16'd0, 64'd0, 16'd0}},
        '{" ",    1'b0, 1'b1, '{REC_END, 8'd0, KIND_WORD, 32'd1, 16'd0, 64'd0, 16'd1}},
        '{"-",    1'b0, 1'b0, '0},
        '{"7",    1'b0, 1'b0, '0},
        '{" ",    1'b0, 1'b1, '{REC_END, 8'd0, KIND_INT, 32'd1, 16'd2, -64'sd7, 16'd2}},
        '{"\"",   1'b0, 1'b0, '0},
        '{8'h00,  1'b0, 1'b1, '{REC_TEXT, 8'h00,  2'd0, 32'd0, 16'd0, 64'd0, 16'd0}},
        '{8'hFF,  1'b0, 1'b1, '{REC_TEXT, 8'hFF,  2'd0, 32'd0, 16'd0, 64'd0, 16'd0}},
        '{"\"",   1'b0, 1'b1, '{REC_END, 8'd0, KIND_STRING, 32'd1, 16'd5, 64'd0, 16'd2}},
        '{"/",    1'b0, 1'b0, '0},
        '{"/",    1'b0, 1'b0, '0},
        '{"x",    1'b0, 1'b0, '0},
        '{8'd10,  1'b0, 1'b0, '0},
        '{8'd10,  1'b0, 1'b0, '0},
        '{"\"",   1'b0, 1'b0, '0},
        '{"q",    1'b0, 1'b0, '0},
        '{8'd10,  1'b0, 1'b1, '{REC_END, 8'd0, KIND_UNTERM, 32'd2, 16'd0, 64'd0, 16'd1}},
        '{"/",    1'b0, 1'b0, '0},
        '{"\"",   1'b0, 1'b0, '0},
        '{"/",    1'b0, 1'b0, '0},
        '{8'd10,  1'b0, 1'b0, '0},
        '{8'd9,   1'b0, 1'b0, '0},
        '{"5",    1'b0, 1'b0, '0},
        '{8'd0,   1'b1, 1'b0, '0}
    };

    logic [7:0] cfg_pairs[6][2] = '{
        '{8'd47, 8'd47}, '{8'd0, 8'd255}, '{8'd255, 8'd0},
        '{"#", "#"}, '{" ", "x"}, '{"-", "-"}
    };

    initial begin
        cf_byte = CFG_FIRST_RST;
        cs_byte = CFG_SECOND_RST;
        clear_lexer();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send(dir_rows[i].ch, dir_rows[i].is_end, dir_rows[i].typed, dir_rows[i].want);
        push_str("9223372036854775807 -9223372036854775808 9223372036854775808 ");
        push_str("-9223372036854775809 +0 \"\"\"a\"b ");
        src_q.push_back(CH_NEWLINE);
        flush_src();
        send(8'd0, 1'b1);

        for (int p = 0; p < 6; p++) begin
            drain();
            apb_write(REG_FIRST, p == 5 ? 8'($urandom) : cfg_pairs[p][0]);
            apb_write(REG_SECOND, p == 5 ? 8'($urandom) : cfg_pairs[p][1]);
            snd_idle = (p < 2) ? 35 : (p < 4) ? 52 : 0;
            rcv_idle = (p < 2) ? 52 : (p < 4) ? 35 : 0;
            if (p == 3) begin
                // long output stall while input keeps coming: queue fills up
                hold_cycles = 300;
            end
            while (bytes_sent < 100 + (p + 1) * 60) gen_line();
            if (p == 5) begin
                drain();
                apb_write(REG_FIRST, 8'd47);
            end
        end
        send(8'd0, 1'b1);
        drain();
        repeat (20) @(posedge aclk);

        $display("covered %0d source bytes, %0d output beats over six marker settings",
                 bytes_sent, beats_seen);
        $display("stalls on both sides plus one long output hold-off; %0d mismatches", errors);
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("stack_language_line_lexer_top_tb: PASS");
        end else begin
            $display("stack_language_line_lexer_top_tb: FAIL");
        end
        $finish;
    end
endmodule
